@@ rtl/core/epaper_dirty_region_refresh_scheduler_assert.svh @@
// Assertion macros shared by the scheduler RTL.
`ifndef EPAPER_DIRTY_REGION_REFRESH_SCHEDULER_ASSERT_SVH
`define EPAPER_DIRTY_REGION_REFRESH_SCHEDULER_ASSERT_SVH

`ifndef SYNTHESIS
`define EDRS_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("edrs assertion failed");
`define EDRS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("edrs assertion failed");
`else
`define EDRS_ASSERT_SAME(label, clk, rstn, ante, cons)
`define EDRS_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

@@ rtl/core/edrs_pkg.sv @@
`timescale 1ns / 1ps

package edrs_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int RECT_DIM_BITS  = 13;
    localparam int DIM_BITS       = 14;
    localparam int SCREEN_BITS    = 13;
    localparam int OUT_H_BITS     = 13;
    localparam int CNT_BITS       = 8;
    localparam int ADDR_BITS      = 4;
    localparam int APB_DATA_BITS  = 32;

    localparam logic [SCREEN_BITS-1:0] DEF_WIDTH  = SCREEN_BITS'(400);
    localparam logic [SCREEN_BITS-1:0] DEF_HEIGHT = SCREEN_BITS'(300);
    localparam logic [CNT_BITS-1:0]    DEF_THRESH = CNT_BITS'(10);
    localparam logic [OUT_H_BITS-1:0]  OUT_H_MAX  = '1;

    typedef enum logic [1:0] {
        MODE_MARK    = 2'd0,
        MODE_PROCESS = 2'd1,
        MODE_FULL    = 2'd2,
        MODE_CLEAR   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_THRESH = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [SCREEN_BITS-1:0] width;
        logic [SCREEN_BITS-1:0] height;
        logic [CNT_BITS-1:0]    thresh;
    } cfg_t;

endpackage

@@ rtl/core/epaper_dirty_region_refresh_scheduler.sv @@
`timescale 1ns / 1ps
// Channel   Dir  Fields (low bit up)
// s_*       in   tdata: rect_x, rect_y, rect_w, rect_h   tuser: mode
// m_*       out  tdata: out_x, out_y, out_w, out_h, pcount
//                tuser: refresh_valid, refresh_full
// APB       in   0x0 panel_w, 0x4 panel_h, 0x8 full_after
//
// One beat per cycle sustained unless m_tready stalls; a beat taken on s_* waits in the
// input register until it fires into the output register and then leaves on m_*.
// The dirty-box merge, 8-pixel alignment and counter update sit between the
// input register and the output register, and the state updates as the output register loads.
// aresetn is synchronous: clears the dirty box, the counter and both pipeline valids.
// A stall on m_tready holds the output register and backs up through s_tready.

`include "epaper_dirty_region_refresh_scheduler_assert.svh"

module epaper_dirty_region_refresh_scheduler #(
    parameter int COORD_BITS = edrs_pkg::COORD_BITS_DEF,
    localparam int IN_BITS   = 2 * COORD_BITS + 2 * edrs_pkg::RECT_DIM_BITS,
    localparam int IN_W      = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS  = 2 * COORD_BITS + edrs_pkg::DIM_BITS + edrs_pkg::OUT_H_BITS
                               + edrs_pkg::CNT_BITS,
    localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [IN_W-1:0]                      s_tdata,  // rect_x, rect_y, rect_w, rect_h
    input  logic [1:0]                           s_tuser,  // mode
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [OUT_W-1:0]                     m_tdata,  // out_x, out_y, out_w, out_h, pcount
    output logic [1:0]                           m_tuser,  // refresh_valid, refresh_full
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [edrs_pkg::ADDR_BITS-1:0]       paddr,
    input  logic [edrs_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [edrs_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                 pready
);

    localparam int RB = edrs_pkg::RECT_DIM_BITS;

    edrs_pkg::cfg_t                  cfg;

    logic                            in_valid_reg;
    edrs_pkg::mode_t                 in_mode_reg;
    logic [COORD_BITS-1:0]           in_x_reg, in_y_reg;
    logic [RB-1:0]                   in_w_reg, in_h_reg;

    logic                            out_valid_reg;
    logic [OUT_W-1:0]                out_data_reg;
    logic [1:0]                      out_user_reg;

    logic                            out_ready;
    logic                            fire;

    logic                            res_valid, res_full;
    logic [COORD_BITS-1:0]           res_x, res_y;
    logic [edrs_pkg::DIM_BITS-1:0]   res_w;
    logic [edrs_pkg::OUT_H_BITS-1:0] res_h;
    logic [edrs_pkg::CNT_BITS-1:0]   res_cnt;

    assign out_ready = !out_valid_reg || m_tready;
    assign fire      = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || fire;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_user_reg;

    edrs_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    edrs_engine #(
        .COORD_BITS (COORD_BITS)
    ) u_engine (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .fire          (fire),
        .mode          (in_mode_reg),
        .rect_x        (in_x_reg),
        .rect_y        (in_y_reg),
        .rect_w        (in_w_reg),
        .rect_h        (in_h_reg),
        .cfg           (cfg),
        .refresh_valid (res_valid),
        .refresh_full  (res_full),
        .out_x         (res_x),
        .out_y         (res_y),
        .out_w         (res_w),
        .out_h         (res_h),
        .pcount        (res_cnt)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_mode_reg <= edrs_pkg::mode_t'(s_tuser);
            in_x_reg    <= s_tdata[COORD_BITS-1:0];
            in_y_reg    <= s_tdata[2*COORD_BITS-1:COORD_BITS];
            in_w_reg    <= s_tdata[2*COORD_BITS+RB-1:2*COORD_BITS];
            in_h_reg    <= s_tdata[2*COORD_BITS+2*RB-1:2*COORD_BITS+RB];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_data_reg <= OUT_W'({res_cnt, res_h, res_w, res_y, res_x});
            out_user_reg <= {res_full, res_valid};
        end
    end

    `EDRS_ASSERT_SAME(a_stall_source, aclk, aresetn, !s_tready,
                      in_valid_reg && m_tvalid && !m_tready)
    `EDRS_ASSERT_SAME(a_idle_region_zero, aclk, aresetn, m_tvalid && !m_tuser[0],
                      m_tuser[1] == 1'b0 && m_tdata[OUT_BITS-edrs_pkg::CNT_BITS-1:0] == '0)
    `EDRS_ASSERT_SAME(a_partial_aligned, aclk, aresetn, m_tvalid && m_tuser[0] && !m_tuser[1],
                      m_tdata[2*COORD_BITS+2:2*COORD_BITS] == 3'b000 && m_tdata[2:0] == 3'b000)
    `EDRS_ASSERT_SAME(a_full_clears_count, aclk, aresetn, m_tvalid && m_tuser[1],
                      m_tdata[OUT_BITS-1:OUT_BITS-edrs_pkg::CNT_BITS] == '0)
    `EDRS_ASSERT_NEXT(a_fire_loads_output, aclk, aresetn, fire, m_tvalid)

endmodule

@@ rtl/core/edrs_cfg.sv @@
`timescale 1ns / 1ps

module edrs_cfg (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [edrs_pkg::ADDR_BITS-1:0]         paddr,
    input  logic [edrs_pkg::APB_DATA_BITS-1:0]     pwdata,
    output logic [edrs_pkg::APB_DATA_BITS-1:0]     prdata,
    output logic                                   pready,
    output edrs_pkg::cfg_t                         cfg
);

    edrs_pkg::cfg_t     cfg_reg;
    edrs_pkg::cfg_t     cfg_next;
    edrs_pkg::reg_idx_t idx;
    logic               wr_en;

    assign pready = 1'b1;
    assign idx    = edrs_pkg::reg_idx_t'(paddr[edrs_pkg::ADDR_BITS-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                edrs_pkg::REG_WIDTH:  cfg_next.width  = pwdata[edrs_pkg::SCREEN_BITS-1:0];
                edrs_pkg::REG_HEIGHT: cfg_next.height = pwdata[edrs_pkg::SCREEN_BITS-1:0];
                edrs_pkg::REG_THRESH: cfg_next.thresh = pwdata[edrs_pkg::CNT_BITS-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (idx)
            edrs_pkg::REG_WIDTH:  prdata = edrs_pkg::APB_DATA_BITS'(cfg_reg.width);
            edrs_pkg::REG_HEIGHT: prdata = edrs_pkg::APB_DATA_BITS'(cfg_reg.height);
            edrs_pkg::REG_THRESH: prdata = edrs_pkg::APB_DATA_BITS'(cfg_reg.thresh);
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.width  <= edrs_pkg::DEF_WIDTH;
            cfg_reg.height <= edrs_pkg::DEF_HEIGHT;
            cfg_reg.thresh <= edrs_pkg::DEF_THRESH;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ rtl/core/edrs_engine.sv @@
`timescale 1ns / 1ps

module edrs_engine #(
    parameter int COORD_BITS = edrs_pkg::COORD_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 fire,
    input  edrs_pkg::mode_t                      mode,
    input  logic [COORD_BITS-1:0]                rect_x,
    input  logic [COORD_BITS-1:0]                rect_y,
    input  logic [edrs_pkg::RECT_DIM_BITS-1:0]   rect_w,
    input  logic [edrs_pkg::RECT_DIM_BITS-1:0]   rect_h,
    input  edrs_pkg::cfg_t                       cfg,
    output logic                                 refresh_valid,
    output logic                                 refresh_full,
    output logic [COORD_BITS-1:0]                out_x,
    output logic [COORD_BITS-1:0]                out_y,
    output logic [edrs_pkg::DIM_BITS-1:0]        out_w,
    output logic [edrs_pkg::OUT_H_BITS-1:0]      out_h,
    output logic [edrs_pkg::CNT_BITS-1:0]        pcount
);

    localparam int DB = edrs_pkg::DIM_BITS;
    localparam int SW = ((COORD_BITS > DB) ? COORD_BITS : DB) + 2;

    logic                                dirty_valid_reg, dirty_valid_next;
    logic [COORD_BITS-1:0]               dirty_left_reg, dirty_left_next;
    logic [COORD_BITS-1:0]               dirty_top_reg, dirty_top_next;
    logic [DB-1:0]                       dirty_width_reg, dirty_width_next;
    logic [DB-1:0]                       dirty_height_reg, dirty_height_next;
    logic [edrs_pkg::CNT_BITS-1:0]       count_reg, count_next;

    logic [SW-1:0]                       r0, b0, r1, b1, rr, bb;
    logic [COORD_BITS-1:0]               lmin, tmin, ax;
    logic [SW-1:0]                       ar;
    logic [DB-1:0]                       merged_w, merged_h, part_w;
    logic [edrs_pkg::OUT_H_BITS-1:0]     part_h;
    logic [edrs_pkg::CNT_BITS-1:0]       thr, cnt_inc;
    logic [edrs_pkg::SCREEN_BITS-1:0]    full_w, full_h;

    always_comb begin
        r0 = SW'(dirty_left_reg) + SW'(dirty_width_reg);
        b0 = SW'(dirty_top_reg) + SW'(dirty_height_reg);
        r1 = SW'(rect_x) + SW'(rect_w);
        b1 = SW'(rect_y) + SW'(rect_h);
        rr = (r0 > r1) ? r0 : r1;
        bb = (b0 > b1) ? b0 : b1;
        lmin = (dirty_left_reg < rect_x) ? dirty_left_reg : rect_x;
        tmin = (dirty_top_reg < rect_y) ? dirty_top_reg : rect_y;
        merged_w = DB'(rr - SW'(lmin));
        merged_h = DB'(bb - SW'(tmin));

        // partial window snaps to 8-pixel columns
        ax = {dirty_left_reg[COORD_BITS-1:3], 3'b000};
        ar = (r0 + SW'(7)) & ~SW'(7);
        part_w = DB'(ar - SW'(ax));
        part_h = (dirty_height_reg > DB'(edrs_pkg::OUT_H_MAX))
               ? edrs_pkg::OUT_H_MAX : dirty_height_reg[edrs_pkg::OUT_H_BITS-1:0];

        thr     = (cfg.thresh == '0) ? edrs_pkg::DEF_THRESH : cfg.thresh;
        cnt_inc = (count_reg == '1) ? count_reg : count_reg + 1'b1;
        full_w  = (cfg.width == '0) ? edrs_pkg::DEF_WIDTH : cfg.width;
        full_h  = (cfg.height == '0) ? edrs_pkg::DEF_HEIGHT : cfg.height;
    end

    always_comb begin
        dirty_valid_next  = dirty_valid_reg;
        dirty_left_next   = dirty_left_reg;
        dirty_top_next    = dirty_top_reg;
        dirty_width_next  = dirty_width_reg;
        dirty_height_next = dirty_height_reg;
        count_next        = count_reg;
        refresh_valid     = 1'b0;
        refresh_full      = 1'b0;
        out_x             = '0;
        out_y             = '0;
        out_w             = '0;
        out_h             = '0;
        case (mode)
            edrs_pkg::MODE_MARK: begin
                if (rect_w != '0 && rect_h != '0) begin
                    dirty_valid_next = 1'b1;
                    if (dirty_valid_reg) begin
                        dirty_left_next   = lmin;
                        dirty_top_next    = tmin;
                        dirty_width_next  = merged_w;
                        dirty_height_next = merged_h;
                    end else begin
                        dirty_left_next   = rect_x;
                        dirty_top_next    = rect_y;
                        dirty_width_next  = DB'(rect_w);
                        dirty_height_next = DB'(rect_h);
                    end
                end
            end
            edrs_pkg::MODE_PROCESS: begin
                if (dirty_valid_reg) begin
                    dirty_valid_next  = 1'b0;
                    dirty_left_next   = '0;
                    dirty_top_next    = '0;
                    dirty_width_next  = '0;
                    dirty_height_next = '0;
                    refresh_valid     = 1'b1;
                    if (cnt_inc >= thr) begin
                        refresh_full = 1'b1;
                        out_w        = DB'(full_w);
                        out_h        = full_h;
                        count_next   = '0;
                    end else begin
                        out_x      = ax;
                        out_y      = dirty_top_reg;
                        out_w      = part_w;
                        out_h      = part_h;
                        count_next = cnt_inc;
                    end
                end
            end
            edrs_pkg::MODE_FULL: begin
                refresh_valid = 1'b1;
                refresh_full  = 1'b1;
                out_w         = DB'(full_w);
                out_h         = full_h;
                count_next    = '0;
            end
            edrs_pkg::MODE_CLEAR: begin
                count_next = '0;
            end
            default: begin
                count_next = count_reg;
            end
        endcase
        pcount = count_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dirty_valid_reg  <= 1'b0;
            dirty_left_reg   <= '0;
            dirty_top_reg    <= '0;
            dirty_width_reg  <= '0;
            dirty_height_reg <= '0;
            count_reg        <= '0;
        end else if (fire) begin
            dirty_valid_reg  <= dirty_valid_next;
            dirty_left_reg   <= dirty_left_next;
            dirty_top_reg    <= dirty_top_next;
            dirty_width_reg  <= dirty_width_next;
            dirty_height_reg <= dirty_height_next;
            count_reg        <= count_next;
        end
    end

endmodule
